// ===== hw/rtl/link_frame_receiver_unit_assert.svh =====
// Assertion macros for the link frame receiver checker.
// Expects clk and rst in scope at the point of use.
`ifndef LINK_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define LINK_FRAME_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication
`define LFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("link frame receiver: same-cycle check failed");

// next-cycle implication
`define LFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("link frame receiver: next-cycle check failed");

`endif

// ===== hw/rtl/lfr_pkg.sv =====
// Shared constants for the link frame receiver: state, mode and register codes.
// No dependencies.
`default_nettype none

package lfr_pkg;

  localparam int StateW = 4;
  localparam int ModeW  = 3;
  localparam int RegIdxW = 3;

  // receiver state codes
  localparam logic [StateW-1:0] ST_START   = 4'd0;
  localparam logic [StateW-1:0] ST_FLAG    = 4'd1;
  localparam logic [StateW-1:0] ST_ADDR    = 4'd2;
  localparam logic [StateW-1:0] ST_CTRL    = 4'd3;
  localparam logic [StateW-1:0] ST_HDR_OK  = 4'd4;
  localparam logic [StateW-1:0] ST_STUFFED = 4'd5;
  localparam logic [StateW-1:0] ST_CHECK   = 4'd6;
  localparam logic [StateW-1:0] ST_STOP    = 4'd7;
  localparam logic [StateW-1:0] ST_RESEND  = 4'd8;

  // expected frame
  localparam logic [ModeW-1:0] MODE_SET  = 3'd0;
  localparam logic [ModeW-1:0] MODE_UA   = 3'd1;
  localparam logic [ModeW-1:0] MODE_ACK  = 3'd2;
  localparam logic [ModeW-1:0] MODE_INFO = 3'd3;
  localparam logic [ModeW-1:0] MODE_DISC = 3'd4;

  // register indexes (byte address / 4)
  localparam logic [RegIdxW-1:0] REG_FLAG      = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ESCAPE    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_ADDR_SND  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_ADDR_RCV  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_UNNUM     = 3'd4;
  localparam logic [RegIdxW-1:0] REG_ACK       = 3'd5;
  localparam logic [RegIdxW-1:0] REG_INFO      = 3'd6;

endpackage

`default_nettype wire

// ===== hw/rtl/link_frame_receiver_unit.sv =====
// Link frame receiver: takes one received byte per beat, walks the frame
// state machine and returns the new state with done / resend flags. One byte
// is accepted every cycle unless the skid is full; its result is registered.
// The single state register and its next-state logic form the only loop, so
// the rate is one byte per clock unless a stall holds it. A two-entry output
// buffer lets the next byte in while a result still waits. Codes and
// delimiters are set through the APB port. Depends on lfr_pkg.
`default_nettype none

module link_frame_receiver_unit
  import lfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // byte channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [2:0]  mode,
  input  wire logic        frame_number,
  input  wire logic        payload_check_ok,
  input  wire logic        restart,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       recv_state,
  output logic             frame_done,
  output logic             resend_requested,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]  flag_byte;
  logic [7:0]  escape_byte;
  logic [7:0]  address_from_sender;
  logic [7:0]  address_from_receiver;
  logic [23:0] unnumbered_codes;
  logic [31:0] ack_codes;
  logic [15:0] info_codes;

  logic [StateW-1:0] state;
  logic [StateW-1:0] state_next;
  logic [StateW-1:0] cur_state;
  logic [StateW-1:0] skid_state;
  logic              skid_valid;

  logic [7:0] addr_exp;
  logic [7:0] ctrl_exp;
  logic [7:0] rej_other;
  logic       in_acc;
  logic       out_take;
  logic       cfg_wr;
  logic [RegIdxW-1:0] reg_idx;

  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte             <= 8'h7E;
      escape_byte           <= 8'h7D;
      address_from_sender   <= 8'h03;
      address_from_receiver <= 8'h01;
      unnumbered_codes      <= 24'h070B03;
      ack_codes             <= 32'h81018505;
      info_codes            <= 16'h4000;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FLAG:     flag_byte             <= pwdata[7:0];
        REG_ESCAPE:   escape_byte           <= pwdata[7:0];
        REG_ADDR_SND: address_from_sender   <= pwdata[7:0];
        REG_ADDR_RCV: address_from_receiver <= pwdata[7:0];
        REG_UNNUM:    unnumbered_codes      <= pwdata[23:0];
        REG_ACK:      ack_codes             <= pwdata;
        REG_INFO:     info_codes            <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FLAG:     prdata = {24'd0, flag_byte};
      REG_ESCAPE:   prdata = {24'd0, escape_byte};
      REG_ADDR_SND: prdata = {24'd0, address_from_sender};
      REG_ADDR_RCV: prdata = {24'd0, address_from_receiver};
      REG_UNNUM:    prdata = {8'd0, unnumbered_codes};
      REG_ACK:      prdata = ack_codes;
      REG_INFO:     prdata = {16'd0, info_codes};
      default:      prdata = 32'd0;
    endcase
  end

  // expected header bytes for this mode
  always_comb begin
    addr_exp  = (mode == MODE_UA) ? address_from_receiver : address_from_sender;
    rej_other = frame_number ? ack_codes[23:16] : ack_codes[31:24];
    unique case (mode)
      MODE_SET:  ctrl_exp = unnumbered_codes[7:0];
      MODE_UA:   ctrl_exp = unnumbered_codes[15:8];
      MODE_ACK:  ctrl_exp = frame_number ? ack_codes[15:8] : ack_codes[7:0];
      MODE_INFO: ctrl_exp = frame_number ? info_codes[15:8] : info_codes[7:0];
      default:   ctrl_exp = unnumbered_codes[23:16];
    endcase
  end

  always_comb begin
    cur_state  = restart ? ST_START : state;
    state_next = cur_state;
    if (mode <= MODE_DISC) begin
      unique case (cur_state)
        ST_START: state_next = (rx_byte == flag_byte) ? ST_FLAG : ST_START;
        ST_FLAG: begin
          if (rx_byte == flag_byte)     state_next = ST_FLAG;
          else if (rx_byte == addr_exp) state_next = ST_ADDR;
          else                          state_next = ST_START;
        end
        ST_ADDR: begin
          // control code wins over flag, flag over reject
          if (rx_byte == ctrl_exp)                            state_next = ST_CTRL;
          else if (rx_byte == flag_byte)                      state_next = ST_FLAG;
          else if (mode == MODE_ACK && rx_byte == rej_other)  state_next = ST_RESEND;
          else                                                state_next = ST_START;
        end
        ST_CTRL: begin
          if (rx_byte == (addr_exp ^ ctrl_exp)) state_next = ST_HDR_OK;
          else if (rx_byte == flag_byte)        state_next = ST_FLAG;
          else                                  state_next = ST_START;
        end
        ST_HDR_OK: begin
          if (mode == MODE_INFO) begin
            if (rx_byte == escape_byte)    state_next = ST_STUFFED;
            else if (rx_byte != flag_byte) state_next = ST_HDR_OK;
            else                           state_next = ST_CHECK;
          end else begin
            state_next = (rx_byte == flag_byte) ? ST_STOP : ST_START;
          end
        end
        ST_STUFFED: begin
          if (mode == MODE_INFO)
            state_next = (rx_byte == escape_byte) ? ST_STUFFED : ST_HDR_OK;
        end
        ST_CHECK: begin
          if (mode == MODE_INFO)
            state_next = payload_check_ok ? ST_STOP : ST_START;
        end
        default: state_next = cur_state;
      endcase
    end
  end

  assign in_stall = skid_valid;
  assign in_acc   = in_valid & ~in_stall;
  assign out_take = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_START;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        state <= state_next;
      end
      if (out_take || !out_valid) begin
        // skid has priority; no beat is taken while it is full
        out_valid  <= skid_valid | in_acc;
        skid_valid <= 1'b0;
      end else if (in_acc) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        recv_state <= skid_state;
      end else if (in_acc) begin
        recv_state <= state_next;
      end
    end else if (in_acc) begin
      skid_state <= state_next;
    end
  end

  assign frame_done       = (recv_state == ST_STOP);
  assign resend_requested = (recv_state == ST_RESEND);

endmodule

`default_nettype wire

// ===== hw/rtl/lfr_checker.sv =====
// Port-level checks for link_frame_receiver_unit, bound to every instance of it.
// Depends on lfr_pkg and link_frame_receiver_unit_assert.svh.
`default_nettype none

`include "link_frame_receiver_unit_assert.svh"

module lfr_checker
  import lfr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  rx_byte,
  input wire logic [2:0]  mode,
  input wire logic        frame_number,
  input wire logic        payload_check_ok,
  input wire logic        restart,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [3:0]  recv_state,
  input wire logic        frame_done,
  input wire logic        resend_requested,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [4:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  logic in_beat;
  logic unused_ok;

  assign in_beat = in_valid & ~in_stall;
  assign unused_ok = ^{rx_byte, mode, frame_number, payload_check_ok,
                       psel, penable, pwrite, paddr, pwdata, prdata, pready};

  // flags agree with the reported state
  `LFR_ASSERT_NOW(a_flags, out_valid, (frame_done == (recv_state == ST_STOP)) && (resend_requested == (recv_state == ST_RESEND)))

  // a stalled result beat holds
  `LFR_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(recv_state))

  // no result appears without a byte behind it
  `LFR_ASSERT_NEXT(a_no_spurious, !out_valid && !in_beat, !out_valid)

  // restart goes back to the start of the frame: only start or flag can follow
  `LFR_ASSERT_NEXT(a_restart, in_beat && restart && !out_valid, out_valid && (recv_state == ST_START || recv_state == ST_FLAG))

endmodule

bind link_frame_receiver_unit lfr_checker u_lfr_checker (.*);

`default_nettype wire

// ===== bench/tb_link_frame_receiver_unit.sv =====
// Self-checking bench for link_frame_receiver_unit: byte beats in, one state result out.
// Holds its own frame state predictor and register shadows; drives the APB port.
// Depends on lfr_pkg and link_frame_receiver_unit.
`timescale 1ns / 100ps

module tb_link_frame_receiver_unit;
  import lfr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 200;
  localparam logic [RegIdxW-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] mode;
    logic       nr;
    logic       chk_ok;
    logic       restart;
  } rx_beat_t;

  typedef struct {
    logic [3:0] state;
    logic       done;
    logic       resend;
  } rx_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  rx_byte;
  logic [2:0]  mode;
  logic        frame_number;
  logic        payload_check_ok;
  logic        restart;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  recv_state;
  logic        frame_done;
  logic        resend_requested;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // register shadows and predicted receiver state
  logic [7:0]  cfg_flag;
  logic [7:0]  cfg_escape;
  logic [7:0]  cfg_addr_snd;
  logic [7:0]  cfg_addr_rcv;
  logic [23:0] cfg_unnum;
  logic [31:0] cfg_ack;
  logic [15:0] cfg_info;
  logic [3:0]  rx_state_model;

  rx_result_t  expected_states[$];

  int unsigned beats_sent;
  int unsigned results_checked;
  int unsigned reg_writes;
  int unsigned error_count;
  int unsigned quiet_cycles;
  bit          idle_on;
  bit          drain_each_frame;

  link_frame_receiver_unit DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .mode             (mode),
    .frame_number     (frame_number),
    .payload_check_ok (payload_check_ok),
    .restart          (restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .recv_state       (recv_state),
    .frame_done       (frame_done),
    .resend_requested (resend_requested),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] ctrl_code(input logic [2:0] md, input logic nr);
    case (md)
      MODE_SET:  return cfg_unnum[7:0];
      MODE_UA:   return cfg_unnum[15:8];
      MODE_ACK:  return nr ? cfg_ack[15:8] : cfg_ack[7:0];
      MODE_INFO: return nr ? cfg_info[15:8] : cfg_info[7:0];
      default:   return cfg_unnum[23:16];
    endcase
  endfunction

  // REJ carrying the other sequence number
  function automatic logic [7:0] rej_other_code(input logic nr);
    return nr ? cfg_ack[23:16] : cfg_ack[31:24];
  endfunction

  function automatic logic [3:0] next_rx_state(input logic [3:0] st, input rx_beat_t bt);
    logic [7:0] adr;
    logic [7:0] ctl;
    if (bt.restart) st = ST_START;
    if (bt.mode > MODE_DISC) return st;
    adr = (bt.mode == MODE_UA) ? cfg_addr_rcv : cfg_addr_snd;
    ctl = ctrl_code(bt.mode, bt.nr);
    case (st)
      ST_START: return (bt.data == cfg_flag) ? ST_FLAG : ST_START;
      ST_FLAG: begin
        if (bt.data == cfg_flag) return ST_FLAG;
        if (bt.data == adr) return ST_ADDR;
        return ST_START;
      end
      ST_ADDR: begin
        if (bt.data == ctl) return ST_CTRL;
        if (bt.data == cfg_flag) return ST_FLAG;
        if (bt.mode == MODE_ACK && bt.data == rej_other_code(bt.nr)) return ST_RESEND;
        return ST_START;
      end
      ST_CTRL: begin
        if (bt.data == (adr ^ ctl)) return ST_HDR_OK;
        if (bt.data == cfg_flag) return ST_FLAG;
        return ST_START;
      end
      ST_HDR_OK: begin
        if (bt.mode == MODE_INFO) begin
          if (bt.data == cfg_escape) return ST_STUFFED;
          if (bt.data != cfg_flag) return ST_HDR_OK;
          return ST_CHECK;
        end
        return (bt.data == cfg_flag) ? ST_STOP : ST_START;
      end
      ST_STUFFED: begin
        if (bt.mode != MODE_INFO) return st;
        return (bt.data == cfg_escape) ? ST_STUFFED : ST_HDR_OK;
      end
      ST_CHECK: begin
        if (bt.mode != MODE_INFO) return st;
        return bt.chk_ok ? ST_STOP : ST_START;
      end
      default: return st;
    endcase
  endfunction

  function automatic void apply_reg_write(input logic [RegIdxW-1:0] idx, input logic [31:0] val);
    case (idx)
      REG_FLAG:     cfg_flag = val[7:0];
      REG_ESCAPE:   cfg_escape = val[7:0];
      REG_ADDR_SND: cfg_addr_snd = val[7:0];
      REG_ADDR_RCV: cfg_addr_rcv = val[7:0];
      REG_UNNUM:    cfg_unnum = val[23:0];
      REG_ACK:      cfg_ack = val;
      REG_INFO:     cfg_info = val[15:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_beat(input rx_beat_t bt);
    rx_result_t res;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    rx_byte = bt.data;
    mode = bt.mode;
    frame_number = bt.nr;
    payload_check_ok = bt.chk_ok;
    restart = bt.restart;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    rx_state_model = next_rx_state(rx_state_model, bt);
    res.state = rx_state_model;
    res.done = (rx_state_model == ST_STOP);
    res.resend = (rx_state_model == ST_RESEND);
    expected_states.push_back(res);
    beats_sent++;
  endtask

  function automatic rx_beat_t make_beat(input logic [7:0] d, input logic [2:0] md,
                                         input logic nr, input logic ok, input logic rs);
    rx_beat_t bt;
    bt.data = d;
    bt.mode = md;
    bt.nr = nr;
    bt.chk_ok = ok;
    bt.restart = rs;
    return bt;
  endfunction

  function automatic rx_beat_t random_beat();
    return make_beat(8'($urandom), 3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  task automatic wait_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    apply_reg_write(idx, val);
    reg_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // only called with no beats in flight
  task automatic load_registers(input logic [31:0] fl, input logic [31:0] esc,
                                input logic [31:0] snd, input logic [31:0] rcv,
                                input logic [31:0] unnum, input logic [31:0] ack,
                                input logic [31:0] info);
    wait_results();
    write_reg(REG_FLAG, fl);
    write_reg(REG_ESCAPE, esc);
    write_reg(REG_ADDR_SND, snd);
    write_reg(REG_ADDR_RCV, rcv);
    write_reg(REG_UNNUM, unnum);
    write_reg(REG_ACK, ack);
    write_reg(REG_INFO, info);
  endtask

  // Well-formed frame for the current codes, then optional damage.
  task automatic send_frame(input logic [2:0] md, input logic nr, input bit rej_other);
    rx_beat_t   beats[$];
    rx_beat_t   bt;
    logic [7:0] adr;
    logic [7:0] ctl;
    int         pos;
    adr = (md == MODE_UA) ? cfg_addr_rcv : cfg_addr_snd;
    ctl = rej_other ? rej_other_code(nr) : ctrl_code(md, nr);
    bt = make_beat(cfg_flag, md, nr, 1'b0, $urandom_range(0, 7) != 0);
    beats.push_back(bt);
    bt.restart = 1'b0;
    if ($urandom_range(0, 5) == 0) beats.push_back(bt);
    bt.data = adr;
    beats.push_back(bt);
    bt.data = ctl;
    beats.push_back(bt);
    if (!rej_other) begin
      bt.data = adr ^ ctl;
      beats.push_back(bt);
      if (md == MODE_INFO) begin
        repeat ($urandom_range(0, 8)) begin
          bt.data = ($urandom_range(0, 3) == 0) ? cfg_escape : 8'($urandom);
          beats.push_back(bt);
        end
        bt.data = cfg_flag;
        beats.push_back(bt);
        bt.data = 8'($urandom);   // check byte, value is don't-care
        beats.push_back(bt);
      end else begin
        bt.data = cfg_flag;
        beats.push_back(bt);
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      pos = $urandom_range(0, beats.size() - 1);
      beats[pos].data = $urandom_range(0, 1) ? cfg_flag : 8'($urandom);
    end
    // mode switched mid-frame
    if ($urandom_range(0, 9) == 0) begin
      pos = $urandom_range(0, beats.size() - 1);
      beats[pos].mode = 3'($urandom);
    end
    if ($urandom_range(0, 11) == 0) begin
      pos = $urandom_range(0, beats.size() - 1);
      beats[pos].restart = 1'b1;
    end
    if ($urandom_range(0, 11) == 0) begin
      pos = $urandom_range(0, beats.size() - 1);
      beats[pos].nr = ~beats[pos].nr;
    end
    foreach (beats[i]) begin
      beats[i].chk_ok = 1'($urandom);
      send_beat(beats[i]);
    end
  endtask

  task automatic run_random_traffic(input int unsigned n_beats);
    int unsigned stop_at;
    rx_beat_t    bt;
    logic [2:0]  md;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      case ($urandom_range(0, 11))
        0: send_beat(random_beat());
        1: begin
          bt = random_beat();
          bt.mode = 3'($urandom_range(MODE_DISC + 1, 7));
          send_beat(bt);
        end
        default: begin
          md = 3'($urandom_range(MODE_SET, MODE_DISC));
          send_frame(md, 1'($urandom), md == MODE_ACK && $urandom_range(0, 2) == 0);
        end
      endcase
      if (drain_each_frame) wait_results();
    end
  endtask

  // ---------------------------------------------------------------- tests

  // reset codes: flag 7E, escape 7D, addresses 03 / 01
  task automatic test_directed_frames();
    // SET accepted
    send_beat(make_beat(cfg_flag, MODE_SET, 1'b0, 1'b0, 1'b1));
    send_beat(make_beat(cfg_addr_snd, MODE_SET, 1'b0, 1'b0, 1'b0));
    send_beat(make_beat(cfg_unnum[7:0], MODE_SET, 1'b0, 1'b0, 1'b0));
    send_beat(make_beat(cfg_addr_snd ^ cfg_unnum[7:0], MODE_SET, 1'b0, 1'b0, 1'b0));
    send_beat(make_beat(cfg_flag, MODE_SET, 1'b0, 1'b0, 1'b0));
    // UA from the receiver address; restart leaves stop
    send_beat(make_beat(cfg_flag, MODE_UA, 1'b1, 1'b0, 1'b1));
    send_beat(make_beat(cfg_addr_rcv, MODE_UA, 1'b1, 1'b0, 1'b0));
    send_beat(make_beat(cfg_unnum[15:8], MODE_UA, 1'b1, 1'b0, 1'b0));
    send_beat(make_beat(cfg_addr_rcv ^ cfg_unnum[15:8], MODE_UA, 1'b1, 1'b0, 1'b0));
    send_beat(make_beat(cfg_flag, MODE_UA, 1'b1, 1'b0, 1'b0));
    // REJ of the other number while expecting 0 -> resend
    send_beat(make_beat(cfg_flag, MODE_ACK, 1'b0, 1'b1, 1'b1));
    send_beat(make_beat(cfg_addr_snd, MODE_ACK, 1'b0, 1'b1, 1'b0));
    send_beat(make_beat(cfg_ack[31:24], MODE_ACK, 1'b0, 1'b1, 1'b0));
    // I-frame 1 with escapes and a 0xFF payload byte, check passes
    send_beat(make_beat(cfg_flag, MODE_INFO, 1'b1, 1'b0, 1'b1));
    send_beat(make_beat(cfg_addr_snd, MODE_INFO, 1'b1, 1'b0, 1'b0));
    send_beat(make_beat(cfg_info[15:8], MODE_INFO, 1'b1, 1'b0, 1'b0));
    send_beat(make_beat(cfg_addr_snd ^ cfg_info[15:8], MODE_INFO, 1'b1, 1'b0, 1'b0));
    send_beat(make_beat(cfg_escape, MODE_INFO, 1'b1, 1'b0, 1'b0));
    send_beat(make_beat(cfg_escape, MODE_INFO, 1'b1, 1'b0, 1'b0));
    send_beat(make_beat(8'hFF, MODE_INFO, 1'b1, 1'b0, 1'b0));
    send_beat(make_beat(cfg_flag, MODE_INFO, 1'b1, 1'b0, 1'b0));
    send_beat(make_beat(8'h00, MODE_INFO, 1'b1, 1'b1, 1'b0));
    // I-frame 0 parked in stuffed, then other modes and unknown mode hold it
    send_beat(make_beat(cfg_flag, MODE_INFO, 1'b0, 1'b0, 1'b1));
    send_beat(make_beat(cfg_addr_snd, MODE_INFO, 1'b0, 1'b0, 1'b0));
    send_beat(make_beat(cfg_info[7:0], MODE_INFO, 1'b0, 1'b0, 1'b0));
    send_beat(make_beat(cfg_addr_snd ^ cfg_info[7:0], MODE_INFO, 1'b0, 1'b0, 1'b0));
    send_beat(make_beat(cfg_escape, MODE_INFO, 1'b0, 1'b0, 1'b0));
    send_beat(make_beat(8'h55, MODE_DISC, 1'b0, 1'b1, 1'b0));
    send_beat(make_beat(8'hAA, 3'd7, 1'b1, 1'b1, 1'b0));
  endtask

  task automatic test_random_traffic_defaults();
    run_random_traffic(150);
  endtask

  // all-zero, all-one, and a setting where codes collide with flag / escape
  task automatic test_register_extremes();
    load_registers(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    run_random_traffic(40);
    load_registers('1, '1, '1, '1, '1, '1, '1);
    write_reg(REG_UNUSED, 32'h0000_0000);
    run_random_traffic(40);
    load_registers(32'h7E, 32'h7E, 32'h03, 32'h7E, 32'h7E7E7E, 32'h7E7E_7E7E, 32'h7E7E);
    run_random_traffic(40);
  endtask

  task automatic test_random_registers();
    for (int round = 0; round < 3; round++) begin
      load_registers($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      write_reg(REG_UNUSED, $urandom);
      drain_each_frame = (round == 0);
      run_random_traffic(70);
    end
    drain_each_frame = 1'b0;
  endtask

  task automatic test_back_to_back();
    load_registers(32'h7E, 32'h7D, 32'h03, 32'h01, 32'h070B03, 32'h8101_8505, 32'h4000);
    idle_on = 1'b0;
    run_random_traffic(150);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    out_stall = 1'b0;
    forever begin
      int unsigned stall_left;
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall = 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rx_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_states.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected result beat, state %0d", $time, recv_state);
      end else begin
        want = expected_states.pop_front();
        results_checked++;
        if (recv_state !== want.state || frame_done !== want.done ||
            resend_requested !== want.resend) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: beat %0d state/done/resend exp %0d/%0b/%0b got %0d/%0b/%0b",
                     $time, results_checked, want.state, want.done, want.resend,
                     recv_state, frame_done, resend_requested);
        end
      end
    end
  end

  // cycles with no handshake on any port
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_states.size());
      $display("link_frame_receiver_unit: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    mode = MODE_SET;
    frame_number = 1'b0;
    payload_check_ok = 1'b0;
    restart = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_flag = 8'h7E;
    cfg_escape = 8'h7D;
    cfg_addr_snd = 8'h03;
    cfg_addr_rcv = 8'h01;
    cfg_unnum = 24'h070B03;
    cfg_ack = 32'h8101_8505;
    cfg_info = 16'h4000;
    rx_state_model = ST_START;
    beats_sent = 0;
    results_checked = 0;
    reg_writes = 0;
    error_count = 0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    drain_each_frame = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_frames();
    test_random_traffic_defaults();
    test_register_extremes();
    test_random_registers();
    test_back_to_back();

    wait_results();
    repeat (4) @(posedge clk);
    if (expected_states.size() != 0) error_count++;
    $display("Sent %0d byte beats (all frame kinds, noise, restarts), checked %0d results",
             beats_sent, results_checked);
    $display("over %0d register writes across default, extreme, colliding and random codes",
             reg_writes);
    if (error_count == 0) begin
      $display("link_frame_receiver_unit: match");
    end else begin
      $display("link_frame_receiver_unit: mismatch");
    end
    $finish;
  end

endmodule
